/* design/cfd_pkg.sv */
// Shared constants, types and the CRC step for the frame deframer.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package cfd_pkg;

  localparam int MAX_PAYLOAD = 96;
  localparam int PL_W        = $clog2(MAX_PAYLOAD + 1);
  localparam int LANES       = 8;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ROWS        = (MAX_PAYLOAD + LANES - 1) / LANES;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NBANKS      = 2;
  localparam int BANK_W      = 1;

  localparam int FLOW_W  = 16;
  localparam int LEN_W   = 7;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 4;
  localparam int CHUNK_W = 64;

  localparam logic [7:0]  SYNC_A        = 8'hAA;
  localparam logic [7:0]  SYNC_B        = 8'h55;
  localparam logic [7:0]  FRAME_VERSION = 8'h01;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [7:0]        msg_type;
    logic [7:0]        src_role;
    logic [7:0]        src_group;
    logic [7:0]        dst_role;
    logic [7:0]        dst_group;
    logic [FLOW_W-1:0] flow_id;
    logic [PL_W-1:0]   len;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [ROW_W-1:0]  row;
    logic [LANE_W-1:0] lane;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
  } rel_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/cfd_ifs.sv */
// Valid/ready channel interfaces: received bytes in, payload chunks out.
// Depends on cfd_pkg for field widths.
`default_nettype none

interface cfd_byte_if;
  import cfd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_chunk_if;
  import cfd_pkg::*;
  logic               valid;
  logic               ready;
  logic [7:0]         msg_type;
  logic [7:0]         src_role;
  logic [7:0]         src_group;
  logic [7:0]         dst_role;
  logic [7:0]         dst_group;
  logic [FLOW_W-1:0]  flow_id;
  logic [LEN_W-1:0]   payload_len;
  logic [IDX_W-1:0]   chunk_index;
  logic [CHUNK_W-1:0] chunk_bytes;
  logic [CNT_W-1:0]   chunk_valid;
  logic               last;
  modport source (output valid, output msg_type, output src_role, output src_group,
                  output dst_role, output dst_group, output flow_id, output payload_len,
                  output chunk_index, output chunk_bytes, output chunk_valid,
                  output last, input ready);
  modport sink (input valid, input msg_type, input src_role, input src_group,
                input dst_role, input dst_group, input flow_id, input payload_len,
                input chunk_index, input chunk_bytes, input chunk_valid,
                input last, output ready);
endinterface

`default_nettype wire

/* design/crc16_frame_deframer_top.sv */
// Top level of the CRC-16 frame deframer.
// Depends on cfd_pkg, cfd_ifs, cfd_front, cfd_queue and cfd_back.
//
// Channel rx carries one received byte per transaction. Channel tx carries one
// payload chunk of up to eight bytes per transaction, with the header fields of
// its frame repeated on every chunk and last set on the final one.
// A frame is AA 55, nine header bytes, the payload and a CRC-16/MODBUS trailer.
// Frames with a wrong version, an oversized length or a bad CRC give nothing.
// Bytes are taken at one per cycle. Payload goes into one of two buffer banks;
// while the bank that the next frame needs still holds an undelivered frame,
// rx stalls once that frame reaches its payload (header bytes are still taken).
// After the last trailer byte the frame is queued; the sequencer pops it, then
// for each chunk reads a buffer row and registers the chunk before offering it,
// so no chunk follows straight on one taken. A frame of n payload bytes gives
// max(1, ceil(n/8)) chunks. A stalled tx holds its chunk steady; the front
// keeps parsing into the other bank meanwhile. Synchronous reset returns the
// parser to the sync hunt and empties the queue; buffers need no clearing.
`default_nettype none

module crc16_frame_deframer_top (
  input  wire         clk,
  input  wire         rst,
  cfd_byte_if.sink    rx,
  cfd_chunk_if.source tx
);
  import cfd_pkg::*;

  logic  push;
  desc_t push_desc;
  wr_t   wr;
  rel_t  rel;
  logic  q_valid;
  desc_t q_desc;
  logic  q_pop;

  cfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr),
    .rel       (rel)
  );

  cfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_desc (q_desc)
  );

  cfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_desc  (q_desc),
    .q_pop   (q_pop),
    .wr      (wr),
    .rel     (rel),
    .tx      (tx)
  );

endmodule

`default_nettype wire

/* design/cfd_front.sv */
// Front end: sync hunt, header capture, CRC check and payload writes.
// Depends on cfd_pkg and cfd_ifs; feeds cfd_queue and the buffer in cfd_back.
`default_nettype none

module cfd_front (
  input  wire                 clk,
  input  wire                 rst,
  cfd_byte_if.sink            rx,
  output logic                push,
  output cfd_pkg::desc_t      push_desc,
  output cfd_pkg::wr_t        wr,
  input  cfd_pkg::rel_t       rel
);
  import cfd_pkg::*;

  localparam logic [2:0] S_HUNT  = 3'd0;
  localparam logic [2:0] S_SYNC  = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_BODY  = 3'd3;
  localparam logic [2:0] S_CRCLO = 3'd4;
  localparam logic [2:0] S_CRCHI = 3'd5;

  localparam logic [3:0] H_VER    = 4'd0;
  localparam logic [3:0] H_TYPE   = 4'd1;
  localparam logic [3:0] H_SROLE  = 4'd2;
  localparam logic [3:0] H_SGROUP = 4'd3;
  localparam logic [3:0] H_DROLE  = 4'd4;
  localparam logic [3:0] H_DGROUP = 4'd5;
  localparam logic [3:0] H_FLOWLO = 4'd6;
  localparam logic [3:0] H_FLOWHI = 4'd7;
  localparam logic [3:0] H_LEN    = 4'd8;

  logic [2:0]        state;
  logic [3:0]        hdr_cnt;
  logic [PL_W-1:0]   off;
  logic [15:0]       crc;
  logic [7:0]        version;
  logic [7:0]        crc_lo;
  logic [NBANKS-1:0] busy;
  logic [BANK_W-1:0] cur;
  desc_t             hdr;
  logic              take;
  logic              frame_ok;
  logic [7:0]        b;

  assign b = rx.rx_byte;

  // Once a frame reaches its payload it needs the current buffer bank to be free.
  assign rx.ready = !(busy[cur] &&
                      (state == S_BODY || state == S_CRCLO || state == S_CRCHI));
  assign take = rx.valid && rx.ready;

  assign frame_ok = (version == FRAME_VERSION) && (crc_lo == crc[7:0]) &&
                    (b == crc[15:8]);
  assign push = take && (state == S_CRCHI) && frame_ok;

  always_comb begin
    push_desc      = hdr;
    push_desc.bank = cur;
  end

  always_comb begin
    wr.en   = take && (state == S_BODY);
    wr.bank = cur;
    wr.row  = ROW_W'(off >> LANE_W);
    wr.lane = off[LANE_W-1:0];
    wr.data = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
      busy  <= '0;
      cur   <= '0;
    end else begin
      if (rel.en) begin
        busy[rel.bank] <= 1'b0;
      end
      if (push) begin
        busy[cur] <= 1'b1;
        cur       <= cur + 1'b1;
      end
      if (take) begin
        case (state)
          S_HUNT: begin
            if (b == SYNC_A) begin
              state <= S_SYNC;
            end
          end
          S_SYNC: begin
            if (b == SYNC_B) begin
              state <= S_HDR;
            end else if (b != SYNC_A) begin
              state <= S_HUNT;
            end
          end
          S_HDR: begin
            if (hdr_cnt == H_LEN) begin
              if (b > 8'(MAX_PAYLOAD)) begin
                state <= S_HUNT;
              end else if (b == 8'd0) begin
                state <= S_CRCLO;
              end else begin
                state <= S_BODY;
              end
            end
          end
          S_BODY: begin
            if (off + 1'b1 == hdr.len) begin
              state <= S_CRCLO;
            end
          end
          S_CRCLO: state <= S_CRCHI;
          S_CRCHI: state <= S_HUNT;
          default: state <= S_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      case (state)
        S_SYNC: begin
          hdr_cnt <= H_VER;
          crc     <= CRC_INIT;
        end
        S_HDR: begin
          crc     <= crc16_update(crc, b);
          hdr_cnt <= hdr_cnt + 4'd1;
          off     <= '0;
          case (hdr_cnt)
            H_VER:    version       <= b;
            H_TYPE:   hdr.msg_type  <= b;
            H_SROLE:  hdr.src_role  <= b;
            H_SGROUP: hdr.src_group <= b;
            H_DROLE:  hdr.dst_role  <= b;
            H_DGROUP: hdr.dst_group <= b;
            H_FLOWLO: hdr.flow_id[7:0]  <= b;
            H_FLOWHI: hdr.flow_id[15:8] <= b;
            H_LEN:    hdr.len       <= PL_W'(b);
            default:  hdr.bank      <= hdr.bank;
          endcase
        end
        S_BODY: begin
          crc <= crc16_update(crc, b);
          off <= off + 1'b1;
        end
        S_CRCLO: crc_lo <= b;
        default: crc_lo <= crc_lo;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/cfd_queue.sv */
// Two-entry queue of accepted frame descriptors between front and back end.
// Depends on cfd_pkg for the descriptor type.
`default_nettype none

module cfd_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  cfd_pkg::desc_t  push_desc,
  input  wire             pop,
  output logic            valid,
  output cfd_pkg::desc_t  head_desc
);
  import cfd_pkg::*;

  desc_t             slots [NBANKS];
  logic [BANK_W-1:0] rd_ptr;
  logic [BANK_W-1:0] wr_ptr;
  logic [BANK_W:0]   count;

  assign valid     = (count != '0);
  assign head_desc = slots[rd_ptr];

  // Every queued frame holds one buffer bank, so the queue cannot overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{BANK_W{1'b0}}, push} - {{BANK_W{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

endmodule

`default_nettype wire

/* design/cfd_back.sv */
// Back end: payload buffer banks and the chunk sequencer with its output register.
// Depends on cfd_pkg and cfd_ifs; takes descriptors from cfd_queue.
`default_nettype none

module cfd_back (
  input  wire             clk,
  input  wire             rst,
  input  wire             q_valid,
  input  cfd_pkg::desc_t  q_desc,
  output logic            q_pop,
  input  cfd_pkg::wr_t    wr,
  output cfd_pkg::rel_t   rel,
  cfd_chunk_if.source     tx
);
  import cfd_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_SEND = 2'd2;
  localparam int RW = PL_W + 1;

  logic [7:0]         mem [NBANKS][ROWS][LANES];
  logic [7:0]         rdata [LANES];
  logic               rd_en;
  logic [BANK_W-1:0]  rd_bank;
  logic [ROW_W-1:0]   rd_row;

  logic [1:0]         state;
  desc_t              cur;
  logic [ROW_W-1:0]   k;
  logic [RW-1:0]      rem;
  logic [CNT_W-1:0]   cnt;
  logic               is_last;
  logic [CHUNK_W-1:0] bytes;
  logic               adv;

  logic [IDX_W-1:0]   idx_r;
  logic [CHUNK_W-1:0] bytes_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               last_r;

  assign adv   = (state == B_SEND) && tx.ready;
  assign q_pop = (state == B_IDLE) && q_valid;
  assign rd_en = q_pop || (adv && !last_r);
  assign rd_bank = (state == B_IDLE) ? q_desc.bank : cur.bank;
  assign rd_row  = (state == B_IDLE) ? '0 : k + 1'b1;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank][wr.row][wr.lane] <= wr.data;
    end
    if (rd_en) begin
      rdata <= mem[rd_bank][rd_row];
    end
  end

  // Bytes left from this chunk onwards; an empty payload gives a single empty chunk.
  always_comb begin
    rem = RW'(cur.len) - RW'({k, {LANE_W{1'b0}}});
    if (cur.len == '0) begin
      cnt     = '0;
      is_last = 1'b1;
    end else if (rem > RW'(LANES)) begin
      cnt     = CNT_W'(LANES);
      is_last = 1'b0;
    end else begin
      cnt     = CNT_W'(rem);
      is_last = 1'b1;
    end
    for (int i = 0; i < LANES; i++) begin
      bytes[i*8 +: 8] = (CNT_W'(i) < cnt) ? rdata[i] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            state <= B_READ;
          end
        end
        B_READ: state <= B_SEND;
        B_SEND: begin
          if (tx.ready) begin
            state <= last_r ? B_IDLE : B_READ;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_desc;
      k   <= '0;
    end
    if (adv && !last_r) begin
      k <= k + 1'b1;
    end
    if (state == B_READ) begin
      idx_r   <= IDX_W'(k);
      bytes_r <= bytes;
      cnt_r   <= cnt;
      last_r  <= is_last;
    end
  end

  assign rel.en   = adv && last_r;
  assign rel.bank = cur.bank;

  assign tx.valid       = (state == B_SEND);
  assign tx.msg_type    = cur.msg_type;
  assign tx.src_role    = cur.src_role;
  assign tx.src_group   = cur.src_group;
  assign tx.dst_role    = cur.dst_role;
  assign tx.dst_group   = cur.dst_group;
  assign tx.flow_id     = cur.flow_id;
  assign tx.payload_len = LEN_W'(cur.len);
  assign tx.chunk_index = idx_r;
  assign tx.chunk_bytes = bytes_r;
  assign tx.chunk_valid = cnt_r;
  assign tx.last        = last_r;

endmodule

`default_nettype wire
